@@ rtl/core/pfb_pkg.sv @@
// Shared constants, codes and types of the page framebuffer dirty-flush block.
// No dependencies; every other file in rtl/core imports this package.
package pfb_pkg;

    // Frame geometry
    localparam int WIDTH       = 128;
    localparam int HEIGHT      = 64;
    localparam int PAGES       = (HEIGHT + 7) / 8;
    localparam int STORE_BYTES = WIDTH * PAGES;

    // Dirty marks are kept as 32-bit rows, one page split into column blocks
    localparam int ROW_BITS   = 32;
    localparam int COL_BLKS   = (WIDTH + ROW_BITS - 1) / ROW_BITS;
    localparam int DIRTY_ROWS = PAGES * COL_BLKS;

    localparam int AW  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int RW  = (DIRTY_ROWS > 1) ? $clog2(DIRTY_ROWS) : 1;
    localparam int BKW = (COL_BLKS > 1) ? $clog2(COL_BLKS) : 1;
    localparam int PGW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int BW  = $clog2(ROW_BITS);
    localparam int CW  = BKW + BW;
    localparam int CXW = CW + 1;

    localparam int RUN_MAX = 32;
    localparam int LIM_W   = 6;
    localparam logic [LIM_W-1:0] LIM_RESET = 6'd31;

    // Input codes
    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_FILL  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    localparam logic [1:0] COLOR_CLEAR  = 2'd0;
    localparam logic [1:0] COLOR_TOGGLE = 2'd2;

    typedef enum logic [1:0] {
        CMD_PIXEL = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_FLUSH = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [PGW-1:0]   page;
        logic [CW-1:0]    col;
        logic [2:0]       bit_sel;
        logic [1:0]       color;
        logic             fill_on;
    } cmd_t;

    typedef struct packed {
        logic [2:0] page;
        logic [6:0] column;
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       empty;
    } beat_t;

endpackage

@@ rtl/core/page_framebuffer_dirty_flush.sv @@
// Page framebuffer with dirty-run flush: top level, run-limit register, assertions.
// Pixel write: dispatch with read, then write. Fill: dispatch, then a store sweep. Flush:
// dispatch; read and check per 32-bit dirty row scanned; check and output per emitted
// byte; read and load per row crossing; close, after a failed check if the run stops
// before a row end; output register last. Reset: synchronous, active low; a clear pass
// zeroes the store and marks all bytes dirty with s_tready low; run_limit returns to 31. Uses pfb_pkg.
module page_framebuffer_dirty_flush (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,  // run_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,      // x[7:0], y[14:8], color[16:15], fill_on[17]
    input  logic [1:0]  s_tuser,      // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,      // page[2:0], column[9:3], data[17:10]
    output logic [1:0]  m_tuser,      // first_in_run[0], empty_res[1]
    output logic        m_tlast       // last_in_run
);
    import pfb_pkg::*;

    logic [LIM_W-1:0] run_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_limit_reg <= LIM_RESET;
        end else if (cfg_wr_en) begin
            run_limit_reg <= cfg_wr_data;
        end
    end

    // front end -> queue -> engine
    logic  init_busy, q_full, q_push, q_valid, q_pop;
    cmd_t  f_cmd, q_head;
    beat_t out_beat;

    pfb_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .init_busy (init_busy),
        .q_full    (q_full),
        .push      (q_push),
        .cmd       (f_cmd)
    );

    pfb_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (f_cmd),
        .full     (q_full),
        .valid    (q_valid),
        .pop      (q_pop),
        .head     (q_head)
    );

    pfb_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd       (q_head),
        .cmd_pop   (q_pop),
        .run_limit (run_limit_reg),
        .init_busy (init_busy),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (out_beat)
    );

    assign m_tdata = {6'd0, out_beat.data, out_beat.column, out_beat.page};
    assign m_tuser = {out_beat.empty, out_beat.first};
    assign m_tlast = out_beat.last;

    // empty beat carries nothing else
    a_empty_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (!m_tlast && m_tdata == 24'd0 && !m_tuser[0]))
        else $error("empty beat carries data or flags");

    // no input taken during the post-reset clear pass
    a_init_block: assert property (@(posedge aclk) disable iff (!aresetn)
        init_busy |-> !s_tready)
        else $error("input accepted during clear pass");

    // queue never popped while empty
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("command popped from empty queue");

endmodule

@@ rtl/core/pfb_front.sv @@
// Front end: takes input beats, drops out-of-range pixels and unused ops,
// and turns the rest into commands for the queue. Depends on pfb_pkg.
module pfb_front (
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [23:0]        s_tdata,
    input  logic [1:0]         s_tuser,
    input  logic               init_busy,
    input  logic               q_full,
    output logic               push,
    output pfb_pkg::cmd_t      cmd
);
    import pfb_pkg::*;

    logic [7:0] x;
    logic [6:0] y;
    logic       keep;

    assign x = s_tdata[7:0];
    assign y = s_tdata[14:8];

    assign s_tready = !q_full && !init_busy;

    always_comb begin
        cmd.kind    = CMD_PIXEL;
        cmd.page    = PGW'(y >> 3);
        cmd.col     = CW'(x);
        cmd.bit_sel = y[2:0];
        cmd.color   = s_tdata[16:15];
        cmd.fill_on = s_tdata[17];
        keep        = 1'b0;
        unique case (s_tuser)
            OP_PIXEL: begin
                cmd.kind = CMD_PIXEL;
                keep     = (9'(x) < 9'(WIDTH)) && (8'(y) < 8'(HEIGHT));
            end
            OP_FILL: begin
                cmd.kind = CMD_FILL;
                keep     = 1'b1;
            end
            OP_FLUSH: begin
                cmd.kind = CMD_FLUSH;
                keep     = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = s_tvalid && s_tready && keep;

endmodule

@@ rtl/core/pfb_cmd_queue.sv @@
// Two-entry command queue between the front end and the engine.
// Depends on pfb_pkg for the command type.
module pfb_cmd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  pfb_pkg::cmd_t  push_cmd,
    output logic           full,
    output logic           valid,
    input  logic           pop,
    output pfb_pkg::cmd_t  head
);
    import pfb_pkg::*;

    cmd_t       q_mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign head  = q_mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wp_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= !wp_reg;
            end
            if (pop) begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

@@ rtl/core/pfb_engine.sv @@
// Back end: frame store, dirty-mark rows, and the sequencer for pixel
// read-modify-write, fill/clear sweeps and flush runs. Depends on pfb_pkg.
module pfb_engine (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cmd_valid,
    input  pfb_pkg::cmd_t              cmd,
    output logic                       cmd_pop,
    input  logic [pfb_pkg::LIM_W-1:0]  run_limit,
    output logic                       init_busy,
    output logic                       out_valid,
    input  logic                       out_ready,
    output pfb_pkg::beat_t             out_beat
);
    import pfb_pkg::*;

    typedef enum logic [9:0] {
        S_CLR      = 10'b0000000001,
        S_IDLE     = 10'b0000000010,
        S_PIX_WR   = 10'b0000000100,
        S_SCAN_RD  = 10'b0000001000,
        S_SCAN_CHK = 10'b0000010000,
        S_RUN_CHK  = 10'b0000100000,
        S_RUN_OUT  = 10'b0001000000,
        S_ROW_RD   = 10'b0010000000,
        S_ROW_LD   = 10'b0100000000,
        S_FIN      = 10'b1000000000
    } state_t;

    function automatic logic [AW-1:0] st_addr(input logic [PGW-1:0] pg,
                                              input logic [CW-1:0] col);
        st_addr = AW'(pg) * AW'(WIDTH) + AW'(col);
    endfunction

    function automatic logic [ROW_BITS-1:0] row_mask(input logic [BKW-1:0] bk);
        logic [ROW_BITS-1:0] m;
        for (int i = 0; i < ROW_BITS; i++) begin
            m[i] = ((CXW+1)'(bk) * (CXW+1)'(ROW_BITS) + (CXW+1)'(i))
                   < (CXW+1)'(WIDTH);
        end
        row_mask = m;
    endfunction

    function automatic logic [BW-1:0] first_set(input logic [ROW_BITS-1:0] d);
        logic [BW-1:0] idx;
        idx = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (d[i]) begin
                idx = BW'(i);
            end
        end
        first_set = idx;
    endfunction

    // memories
    logic [7:0]          store_mem [STORE_BYTES];
    logic [ROW_BITS-1:0] dirty_mem [DIRTY_ROWS];
    logic [7:0]          st_q;
    logic [ROW_BITS-1:0] dt_q;

    logic                st_we, st_re, dt_we, dt_re;
    logic [AW-1:0]       st_waddr, st_raddr;
    logic [7:0]          st_wdata;
    logic [RW-1:0]       dt_waddr, dt_raddr;
    logic [ROW_BITS-1:0] dt_wdata;

    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[st_waddr] <= st_wdata;
        end
        if (st_re) begin
            st_q <= store_mem[st_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (dt_we) begin
            dirty_mem[dt_waddr] <= dt_wdata;
        end
        if (dt_re) begin
            dt_q <= dirty_mem[dt_raddr];
        end
    end

    // sequencer state
    state_t              state_reg, state_next;
    logic [AW-1:0]       cnt_reg, cnt_next;
    logic [BKW-1:0]      sw_bk_reg, sw_bk_next;
    logic [7:0]          fill_val_reg, fill_val_next;
    logic                init_reg, init_next;
    logic [RW-1:0]       r_reg, r_next;
    logic [PGW-1:0]      pg_reg, pg_next;
    logic [BKW-1:0]      bk_reg, bk_next;
    logic [BW-1:0]       b_reg, b_next;
    logic [LIM_W-1:0]    n_reg, n_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    cmd_t                pcmd_reg, pcmd_next;
    logic                pend_valid_reg, pend_valid_next;
    beat_t               pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    beat_t               out_reg, out_next;

    logic [LIM_W-1:0]    lim_eff;
    logic [CW-1:0]       col;
    logic                out_free, push_out;
    beat_t               push_beat;
    logic [7:0]          pix_mask, pix_new;
    logic [RW-1:0]       pix_row;
    logic [ROW_BITS-1:0] row_clr;
    logic                cont;

    assign lim_eff = (run_limit == '0) ? LIM_W'(1) :
                     (run_limit > LIM_W'(RUN_MAX)) ? LIM_W'(RUN_MAX) : run_limit;
    assign col      = {bk_reg, b_reg};
    assign out_free = !out_valid_reg || out_ready;

    assign pix_mask = 8'b1 << pcmd_reg.bit_sel;
    assign pix_row  = RW'(pcmd_reg.page) * RW'(COL_BLKS) + RW'(pcmd_reg.col >> BW);
    assign row_clr  = row_reg & ~(ROW_BITS'(1) << b_reg);
    assign cont     = ((LIM_W+1)'(n_reg) + (LIM_W+1)'(1) < (LIM_W+1)'(lim_eff)) &&
                      (CXW'(col) + CXW'(1) < CXW'(WIDTH));

    always_comb begin
        unique case (pcmd_reg.color)
            COLOR_CLEAR:  pix_new = st_q & ~pix_mask;
            COLOR_TOGGLE: pix_new = st_q ^ pix_mask;
            default:      pix_new = st_q | pix_mask;
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        sw_bk_next      = sw_bk_reg;
        fill_val_next   = fill_val_reg;
        init_next       = init_reg;
        r_next          = r_reg;
        pg_next         = pg_reg;
        bk_next         = bk_reg;
        b_next          = b_reg;
        n_next          = n_reg;
        row_next        = row_reg;
        pcmd_next       = pcmd_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        cmd_pop         = 1'b0;
        push_out        = 1'b0;
        push_beat       = pend_reg;
        st_we = 1'b0; st_re = 1'b0; dt_we = 1'b0; dt_re = 1'b0;
        st_waddr = cnt_reg;
        st_raddr = st_addr(pg_reg, col);
        st_wdata = fill_val_reg;
        dt_waddr = r_reg;
        dt_raddr = r_reg;
        dt_wdata = row_reg;

        unique case (state_reg)
            S_CLR: begin
                st_we = 1'b1;
                if (cnt_reg < AW'(DIRTY_ROWS)) begin
                    dt_we    = 1'b1;
                    dt_waddr = RW'(cnt_reg);
                    dt_wdata = row_mask(sw_bk_reg);
                end
                sw_bk_next = (sw_bk_reg == BKW'(COL_BLKS - 1)) ? '0 : sw_bk_reg + 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == AW'(STORE_BYTES - 1)) begin
                    cnt_next   = '0;
                    sw_bk_next = '0;
                    init_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        CMD_PIXEL: begin
                            st_re      = 1'b1;
                            st_raddr   = st_addr(cmd.page, cmd.col);
                            dt_re      = 1'b1;
                            dt_raddr   = RW'(cmd.page) * RW'(COL_BLKS) + RW'(cmd.col >> BW);
                            pcmd_next  = cmd;
                            state_next = S_PIX_WR;
                        end
                        CMD_FILL: begin
                            fill_val_next = {8{cmd.fill_on}};
                            cnt_next      = '0;
                            sw_bk_next    = '0;
                            state_next    = S_CLR;
                        end
                        CMD_FLUSH: begin
                            r_next     = '0;
                            pg_next    = '0;
                            bk_next    = '0;
                            state_next = S_SCAN_RD;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_PIX_WR: begin
                st_we    = 1'b1;
                st_waddr = st_addr(pcmd_reg.page, pcmd_reg.col);
                st_wdata = pix_new;
                if (pix_new != st_q) begin
                    dt_we    = 1'b1;
                    dt_waddr = pix_row;
                    dt_wdata = dt_q | (ROW_BITS'(1) << pcmd_reg.col[BW-1:0]);
                end
                state_next = S_IDLE;
            end
            S_SCAN_RD: begin
                dt_re      = 1'b1;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (dt_q != '0) begin
                    row_next   = dt_q;
                    b_next     = first_set(dt_q);
                    n_next     = '0;
                    state_next = S_RUN_CHK;
                end else if (r_reg == RW'(DIRTY_ROWS - 1)) begin
                    pend_valid_next = 1'b1;
                    pend_next       = '0;
                    pend_next.empty = 1'b1;
                    state_next      = S_FIN;
                end else begin
                    r_next = r_reg + 1'b1;
                    if (bk_reg == BKW'(COL_BLKS - 1)) begin
                        bk_next = '0;
                        pg_next = pg_reg + 1'b1;
                    end else begin
                        bk_next = bk_reg + 1'b1;
                    end
                    state_next = S_SCAN_RD;
                end
            end
            S_RUN_CHK: begin
                if ((n_reg < lim_eff) && (CXW'(col) < CXW'(WIDTH)) && row_reg[b_reg]) begin
                    st_re      = 1'b1;
                    state_next = S_RUN_OUT;
                end else begin
                    dt_we      = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_RUN_OUT: begin
                if (!pend_valid_reg || out_free) begin
                    push_out         = pend_valid_reg;
                    pend_valid_next  = 1'b1;
                    pend_next.page   = 3'(pg_reg);
                    pend_next.column = 7'(col);
                    pend_next.data   = st_q;
                    pend_next.first  = (n_reg == '0);
                    pend_next.last   = 1'b0;
                    pend_next.empty  = 1'b0;
                    row_next         = row_clr;
                    n_next           = n_reg + 1'b1;
                    if (b_reg == BW'(ROW_BITS - 1)) begin
                        dt_we    = 1'b1;
                        dt_wdata = row_clr;
                        if (cont) begin
                            r_next     = r_reg + 1'b1;
                            bk_next    = bk_reg + 1'b1;
                            b_next     = '0;
                            state_next = S_ROW_RD;
                        end else begin
                            state_next = S_FIN;
                        end
                    end else begin
                        b_next     = b_reg + 1'b1;
                        state_next = S_RUN_CHK;
                    end
                end
            end
            S_ROW_RD: begin
                dt_re      = 1'b1;
                state_next = S_ROW_LD;
            end
            S_ROW_LD: begin
                row_next   = dt_q;
                state_next = S_RUN_CHK;
            end
            S_FIN: begin
                if (out_free) begin
                    push_out        = 1'b1;
                    push_beat.last  = !pend_reg.empty;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (push_out) begin
            out_valid_next = 1'b1;
            out_next       = push_beat;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLR;
            cnt_reg        <= '0;
            sw_bk_reg      <= '0;
            fill_val_reg   <= '0;
            init_reg       <= 1'b1;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            sw_bk_reg      <= sw_bk_next;
            fill_val_reg   <= fill_val_next;
            init_reg       <= init_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        r_reg    <= r_next;
        pg_reg   <= pg_next;
        bk_reg   <= bk_next;
        b_reg    <= b_next;
        n_reg    <= n_next;
        row_reg  <= row_next;
        pcmd_reg <= pcmd_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign init_busy = init_reg;
    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

endmodule

@@ tb/page_framebuffer_dirty_flush_tb.sv @@
// Testbench for page_framebuffer_dirty_flush: directed and random pixel, fill and
// flush beats, checked against a behavioral frame store with dirty marks.
// Depends on pfb_pkg and the page_framebuffer_dirty_flush RTL.
module page_framebuffer_dirty_flush_tb;
    import pfb_pkg::*;

    localparam int FRAME_BYTES = 128 * 8;
    localparam longint CYCLE_LIMIT = 2_000_000;
    // engine plus two queued fills can still be busy once all output arrived
    localparam int SETTLE_CYCLES = 3 * FRAME_BYTES + 64;

    // One emitted frame byte as the flush run reports it
    typedef struct packed {
        logic [2:0] page;
        logic [6:0] column;
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       empty;
    } flush_byte_t;

    // Shadow frame store; predicts flush runs and checks emitted bytes
    class flush_scoreboard;
        logic [7:0]  frame[FRAME_BYTES];
        bit          dirty[FRAME_BYTES];
        logic [5:0]  run_limit;
        flush_byte_t pending[$];
        int          errors;
        int          checked;

        function void clear_state();
            foreach (frame[i]) begin
                frame[i] = 8'h00;
                dirty[i] = 1'b1;
            end
            run_limit = 6'd31;
        endfunction

        function void note_command(logic [1:0] op, logic [7:0] x, logic [6:0] y,
                                   logic [1:0] color, logic fill_on);
            int idx;
            int col;
            int lim;
            int n;
            logic [7:0] old_byte;
            logic [7:0] mask;
            logic [7:0] nv;
            flush_byte_t fb;
            if (op == OP_PIXEL) begin
                if (x < 128 && y < 64) begin
                    idx = (y >> 3) * 128 + x;
                    mask = 8'h01 << y[2:0];
                    old_byte = frame[idx];
                    if (color == COLOR_CLEAR) nv = old_byte & ~mask;
                    else if (color == COLOR_TOGGLE) nv = old_byte ^ mask;
                    else nv = old_byte | mask;   // set, and code three acts as set
                    frame[idx] = nv;
                    if (nv != old_byte) dirty[idx] = 1'b1;
                end
            end else if (op == OP_FILL) begin
                foreach (frame[i]) begin
                    frame[i] = fill_on ? 8'hFF : 8'h00;
                    dirty[i] = 1'b1;
                end
            end else if (op == OP_FLUSH) begin
                idx = 0;
                while (idx < FRAME_BYTES && !dirty[idx]) idx++;
                if (idx >= FRAME_BYTES) begin
                    fb = '0;
                    fb.empty = 1'b1;
                    pending.push_back(fb);
                end else begin
                    lim = int'(run_limit);
                    if (lim == 0) lim = 1;
                    if (lim > 32) lim = 32;
                    col = idx % 128;
                    n = 0;
                    // run stops at limit, a clean byte, or the end of the page
                    while (n < lim && col < 128 && dirty[idx]) begin
                        fb = '0;
                        fb.page = 3'(idx / 128);
                        fb.column = 7'(col);
                        fb.data = frame[idx];
                        fb.first = (n == 0);
                        dirty[idx] = 1'b0;
                        pending.push_back(fb);
                        n++;
                        idx++;
                        col++;
                    end
                    fb = pending.pop_back();
                    fb.last = 1'b1;
                    pending.push_back(fb);
                end
            end
        endfunction

        function void check_byte(flush_byte_t got);
            flush_byte_t exp;
            checked++;
            if (pending.size() == 0) begin
                $error("unexpected output beat %p", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.page !== exp.page) begin
                $error("page: expected %0d got %0d", exp.page, got.page); errors++;
            end
            if (got.column !== exp.column) begin
                $error("column: expected %0d got %0d", exp.column, got.column); errors++;
            end
            if (got.data !== exp.data) begin
                $error("data: expected %h got %h", exp.data, got.data); errors++;
            end
            if (got.first !== exp.first) begin
                $error("first_in_run: expected %b got %b", exp.first, got.first); errors++;
            end
            if (got.last !== exp.last) begin
                $error("last_in_run: expected %b got %b", exp.last, got.last); errors++;
            end
            if (got.empty !== exp.empty) begin
                $error("empty_res: expected %b got %b", exp.empty, got.empty); errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [5:0]  cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    flush_scoreboard sb;
    longint cycles = 0;
    int     beats_sent = 0;
    bit     stall_on = 1'b1;   // receiver stall pattern enabled
    int     burst_left = 0;

    always #5 aclk = ~aclk;

    page_framebuffer_dirty_flush u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // Output side: check at the rising edge, stall pattern applied at the falling edge
    always @(posedge aclk) begin
        flush_byte_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.page   = m_tdata[2:0];
            got.column = m_tdata[9:3];
            got.data   = m_tdata[17:10];
            got.first  = m_tuser[0];
            got.empty  = m_tuser[1];
            got.last   = m_tlast;
            sb.check_byte(got);
        end
    end

    always @(negedge aclk) begin
        // runs of free flow, alternating with short bursts of backpressure
        if (!stall_on) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(negedge aclk) begin
        if ((cycles % 4000) == 0) stall_on <= ~stall_on;
    end

    // Send one beat; bursts of random length separated by random gaps.
    // tvalid stays high between beats of a burst and drops only for a gap.
    task automatic send_cmd(logic [1:0] op, logic [7:0] x, logic [6:0] y,
                            logic [1:0] color, logic fill_on);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, fill_on, color, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_command(op, x, y, color, fill_on);
        beats_sent++;
        @(negedge aclk);
    endtask

    // Stop sending, wait until every expected byte arrived, then let the engine settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_limit(logic [5:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.run_limit = v;
    endtask

    task automatic random_cmd();
        int r;
        logic [7:0] x;
        logic [6:0] y;
        r = $urandom_range(0, 99);
        x = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
        y = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 63));
        if (r < 55) send_cmd(OP_PIXEL, x, y, 2'($urandom), 1'b0);
        else if (r < 57) send_cmd(OP_FILL, 8'($urandom), 7'($urandom), 2'($urandom),
                                 1'($urandom));
        else if (r < 59) send_cmd(2'd3, 8'($urandom), 7'($urandom), 2'($urandom),
                                 1'($urandom));
        else send_cmd(OP_FLUSH, 8'($urandom), 7'($urandom), 2'($urandom), 1'($urandom));
    endtask

    initial begin
        sb = new();
        sb.clear_state();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: run limit 1 then flush from reset (everything dirty)
        write_limit(6'd0);                  // zero acts as one
        send_cmd(OP_FLUSH, 8'd0, 7'd0, 2'd0, 1'b0);
        write_limit(6'd63);                 // above 32 clamps; runs stop at page end
        repeat (4) send_cmd(OP_FLUSH, 8'hFF, 7'h7F, 2'd3, 1'b1);
        send_cmd(OP_FILL, 8'hFF, 7'h7F, 2'd3, 1'b1);   // fill on
        write_limit(6'd32);
        repeat (34) send_cmd(OP_FLUSH, 8'd0, 7'd0, 2'd0, 1'b0);
        send_cmd(OP_FLUSH, 8'd0, 7'd0, 2'd0, 1'b0);    // nothing dirty
        send_cmd(OP_PIXEL, 8'd127, 7'd63, 2'd0, 1'b0); // clear corner
        send_cmd(OP_PIXEL, 8'd0, 7'd0, 2'd2, 1'b0);    // toggle
        send_cmd(OP_PIXEL, 8'd1, 7'd9, 2'd3, 1'b0);    // code three sets (no change)
        send_cmd(OP_PIXEL, 8'd128, 7'd5, 2'd0, 1'b0);  // out of frame
        send_cmd(OP_PIXEL, 8'd5, 7'd64, 2'd0, 1'b0);   // out of frame
        send_cmd(2'd3, 8'hAA, 7'h55, 2'd1, 1'b1);      // unused op
        send_cmd(OP_FLUSH, 8'd0, 7'd0, 2'd0, 1'b0);
        send_cmd(OP_FLUSH, 8'd0, 7'd0, 2'd0, 1'b0);
        send_cmd(OP_FILL, 8'd0, 7'd0, 2'd0, 1'b0);     // fill off

        // Random phases across several run limits
        for (int ph = 0; ph < 4; ph++) begin
            write_limit(ph == 0 ? 6'd1 : ph == 1 ? 6'd32 : 6'($urandom_range(2, 31)));
            repeat (18) random_cmd();
        end
        drain();
        $display("sent %0d beats, checked %0d output beats over several run limits",
                 beats_sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
